/* rtl/fpp_pkg.sv */
// Shared types, constants and the CRC-8 helper for the framed packet parser.
// Used by every module under rtl; depends on nothing else.
package fpp_pkg;

    localparam int DATA_W                = 8;
    localparam int LEN_W                 = 7;
    localparam int HDR_LEN_W             = 16;
    localparam int CFG_INDEX_W           = 2;
    localparam int CFG_DATA_W            = 8;
    localparam int PAYLOAD_DEPTH_DEFAULT = 64;
    localparam int QUEUE_DEPTH           = 2;

    localparam logic [DATA_W-1:0] CRC_POLY       = 8'h07;
    localparam logic [DATA_W-1:0] CRC_TOP_BIT    = 8'h80;
    localparam logic [DATA_W-1:0] START_RESET    = 8'hAA;
    localparam logic [DATA_W-1:0] VERSION_RESET  = 8'h01;
    localparam logic [LEN_W-1:0]  LIMIT_RESET    = 7'd64;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_VERSION = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAYLOAD_LIMIT    = 2'd2;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_VERSION = 2'd1,
        ERR_LENGTH  = 2'd2,
        ERR_CRC     = 2'd3
    } err_code_t;

    typedef struct packed {
        logic              is_error;
        err_code_t         error_code;
        logic [DATA_W-1:0] frame_version;
        logic [DATA_W-1:0] frame_command;
        logic [DATA_W-1:0] frame_interface;
        logic [DATA_W-1:0] transaction_id;
        logic [LEN_W-1:0]  payload_length;
    } fpp_cmd_t;

    typedef struct packed {
        logic              is_error;
        err_code_t         error_code;
        logic [DATA_W-1:0] frame_version;
        logic [DATA_W-1:0] frame_command;
        logic [DATA_W-1:0] frame_interface;
        logic [DATA_W-1:0] transaction_id;
        logic [LEN_W-1:0]  payload_length;
        logic              byte_valid;
        logic [DATA_W-1:0] payload_byte;
        logic              last_of_frame;
    } fpp_result_t;

    function automatic logic [DATA_W-1:0] crc_fold(input logic [DATA_W-1:0] crc,
                                                   input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] x;
        x = crc ^ value;
        for (int i = 0; i < DATA_W; i++)
        begin
            if ((x & CRC_TOP_BIT) != '0)
            begin
                x = (x << 1) ^ CRC_POLY;
            end
            else
            begin
                x = x << 1;
            end
        end
        return x;
    endfunction

endpackage

/* rtl/fpp_front.sv */
// Front end of the packet parser: configuration registers, header parsing,
// CRC-8 tracking and payload store writes. Depends on fpp_pkg.
module fpp_front #(
    parameter int PAYLOAD_DEPTH = fpp_pkg::PAYLOAD_DEPTH_DEFAULT,
    parameter int ADDR_W        = 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [fpp_pkg::DATA_W-1:0]       in_byte,
    input  logic                             cfg_we,
    input  logic [fpp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fpp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             q_push,
    output fpp_pkg::fpp_cmd_t                q_entry,
    input  logic                             q_full,
    input  logic                             store_busy,
    output logic                             wr_en,
    output logic [ADDR_W-1:0]                wr_addr,
    output logic [fpp_pkg::DATA_W-1:0]       wr_data
);
    import fpp_pkg::*;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_VER     = 4'd1,
        PH_CMD     = 4'd2,
        PH_IFACE   = 4'd3,
        PH_TXN     = 4'd4,
        PH_LENHI   = 4'd5,
        PH_LENLO   = 4'd6,
        PH_PAYLOAD = 4'd7,
        PH_CRC     = 4'd8
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [DATA_W-1:0]   crc_reg, crc_next;
    logic [DATA_W-1:0]   ver_reg, ver_next;
    logic [DATA_W-1:0]   cmd_reg, cmd_next;
    logic [DATA_W-1:0]   ifc_reg, ifc_next;
    logic [DATA_W-1:0]   txn_reg, txn_next;
    logic [DATA_W-1:0]   len_hi_reg, len_hi_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    count_reg, count_next;
    logic [DATA_W-1:0]   start_reg;
    logic [DATA_W-1:0]   exp_ver_reg;
    logic [LEN_W-1:0]    limit_reg;

    logic                accept;
    logic [HDR_LEN_W-1:0] full_len;
    logic [LEN_W-1:0]    eff_limit;
    logic                len_too_big;
    logic [DATA_W-1:0]   crc_byte;
    logic [LEN_W-1:0]    count_plus;

    always_comb
    begin
        in_ready    = !q_full && !((phase_reg == PH_PAYLOAD) && store_busy);
        accept      = in_valid && in_ready;
        full_len    = {len_hi_reg, in_byte};
        eff_limit   = (limit_reg > LEN_W'(PAYLOAD_DEPTH)) ? LEN_W'(PAYLOAD_DEPTH) : limit_reg;
        len_too_big = full_len > {{(HDR_LEN_W-LEN_W){1'b0}}, eff_limit};
        crc_byte    = crc_fold(crc_reg, in_byte);
        count_plus  = count_reg + LEN_W'(1);

        phase_next  = phase_reg;
        crc_next    = crc_reg;
        ver_next    = ver_reg;
        cmd_next    = cmd_reg;
        ifc_next    = ifc_reg;
        txn_next    = txn_reg;
        len_hi_next = len_hi_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        q_push      = 1'b0;
        q_entry     = '{is_error: 1'b1, error_code: ERR_CRC, frame_version: ver_reg,
                        frame_command: '0, frame_interface: ifc_reg,
                        transaction_id: txn_reg, payload_length: '0};
        wr_en       = 1'b0;
        wr_addr     = count_reg[ADDR_W-1:0];
        wr_data     = in_byte;

        if (accept)
        begin
            unique case (phase_reg)
                PH_VER:
                begin
                    ver_next = in_byte;
                    crc_next = crc_byte;
                    if (in_byte != exp_ver_reg)
                    begin
                        q_push     = 1'b1;
                        q_entry    = '{is_error: 1'b1, error_code: ERR_VERSION,
                                       frame_version: in_byte, frame_command: '0,
                                       frame_interface: '0, transaction_id: '0,
                                       payload_length: '0};
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        phase_next = PH_CMD;
                    end
                end
                PH_CMD:
                begin
                    cmd_next   = in_byte;
                    crc_next   = crc_byte;
                    phase_next = PH_IFACE;
                end
                PH_IFACE:
                begin
                    ifc_next   = in_byte;
                    crc_next   = crc_byte;
                    phase_next = PH_TXN;
                end
                PH_TXN:
                begin
                    txn_next   = in_byte;
                    crc_next   = crc_byte;
                    phase_next = PH_LENHI;
                end
                PH_LENHI:
                begin
                    len_hi_next = in_byte;
                    crc_next    = crc_byte;
                    phase_next  = PH_LENLO;
                end
                PH_LENLO:
                begin
                    crc_next = crc_byte;
                    if (len_too_big)
                    begin
                        q_push          = 1'b1;
                        q_entry.error_code = ERR_LENGTH;
                        phase_next      = PH_HUNT;
                    end
                    else
                    begin
                        len_next   = full_len[LEN_W-1:0];
                        count_next = '0;
                        phase_next = (full_len == '0) ? PH_CRC : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    wr_en      = 1'b1;
                    crc_next   = crc_byte;
                    count_next = count_plus;
                    if (count_plus >= len_reg)
                    begin
                        phase_next = PH_CRC;
                    end
                end
                PH_CRC:
                begin
                    q_push     = 1'b1;
                    phase_next = PH_HUNT;
                    if (in_byte == crc_reg)
                    begin
                        q_entry = '{is_error: 1'b0, error_code: ERR_NONE,
                                    frame_version: ver_reg, frame_command: cmd_reg,
                                    frame_interface: ifc_reg, transaction_id: txn_reg,
                                    payload_length: len_reg};
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    if (in_byte == start_reg)
                    begin
                        crc_next   = '0;
                        phase_next = PH_VER;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            crc_reg     <= '0;
            ver_reg     <= '0;
            cmd_reg     <= '0;
            ifc_reg     <= '0;
            txn_reg     <= '0;
            len_hi_reg  <= '0;
            len_reg     <= '0;
            count_reg   <= '0;
            start_reg   <= START_RESET;
            exp_ver_reg <= VERSION_RESET;
            limit_reg   <= LIMIT_RESET;
        end
        else
        begin
            phase_reg  <= phase_next;
            crc_reg    <= crc_next;
            ver_reg    <= ver_next;
            cmd_reg    <= cmd_next;
            ifc_reg    <= ifc_next;
            txn_reg    <= txn_next;
            len_hi_reg <= len_hi_next;
            len_reg    <= len_next;
            count_reg  <= count_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_START_BYTE:       start_reg   <= cfg_data[DATA_W-1:0];
                    CFG_EXPECTED_VERSION: exp_ver_reg <= cfg_data[DATA_W-1:0];
                    CFG_PAYLOAD_LIMIT:    limit_reg   <= cfg_data[LEN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("Command pushed into a full queue.");

    assert property (@(posedge clk) disable iff (!rst_n) q_push |=> (phase_reg == PH_HUNT))
        else $error("Parser did not return to hunting after a frame outcome.");

    assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> (count_reg < len_reg))
        else $error("Payload write beyond the declared length.");

endmodule

/* rtl/fpp_queue.sv */
// Short command queue between the parser front end and the result back end.
// Depends on fpp_pkg for the command type.
module fpp_queue #(
    parameter int DEPTH = fpp_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fpp_pkg::fpp_cmd_t push_entry,
    output logic              full,
    input  logic              pop,
    output fpp_pkg::fpp_cmd_t pop_entry,
    output logic              not_empty
);
    import fpp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fpp_cmd_t          entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    always_comb
    begin
        full      = (count_reg == CNT_W'(DEPTH));
        not_empty = (count_reg != '0);
        do_push   = push && !full;
        do_pop    = pop && not_empty;
        pop_entry = entries_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

/* rtl/fpp_back.sv */
// Back end of the packet parser: payload store and the sequencer that turns
// queued commands into result beats through an output register. Depends on fpp_pkg.
module fpp_back #(
    parameter int PAYLOAD_DEPTH = fpp_pkg::PAYLOAD_DEPTH_DEFAULT,
    parameter int ADDR_W        = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  fpp_pkg::fpp_cmd_t          q_entry,
    output logic                       q_pop,
    output logic                       store_busy,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [fpp_pkg::DATA_W-1:0] wr_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output fpp_pkg::fpp_result_t       out_result
);
    import fpp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_READ = 2'd1,
        S_LOAD = 2'd2
    } state_t;

    logic [DATA_W-1:0] payload_store_reg [PAYLOAD_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    state_t            state_reg;
    fpp_cmd_t          cmd_reg;
    logic [LEN_W-1:0]  k_reg;
    logic              out_valid_reg;
    fpp_result_t       out_reg;

    logic              load;
    logic              last;
    fpp_result_t       result;

    always_comb
    begin
        store_busy = (state_reg != S_IDLE) || q_valid;
        q_pop      = (state_reg == S_IDLE) && q_valid;
        load       = (state_reg == S_LOAD) && (!out_valid_reg || out_ready);
        last       = (cmd_reg.payload_length == '0) ||
                     ((k_reg + LEN_W'(1)) == cmd_reg.payload_length);

        result.is_error        = cmd_reg.is_error;
        result.error_code      = cmd_reg.error_code;
        result.frame_version   = cmd_reg.frame_version;
        result.frame_command   = cmd_reg.frame_command;
        result.frame_interface = cmd_reg.frame_interface;
        result.transaction_id  = cmd_reg.transaction_id;
        result.payload_length  = cmd_reg.payload_length;
        result.byte_valid      = (cmd_reg.payload_length != '0);
        result.payload_byte    = result.byte_valid ? rd_data_reg : '0;
        result.last_of_frame   = last;

        out_valid  = out_valid_reg;
        out_result = out_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            payload_store_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= payload_store_reg[k_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= result;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg   <= q_entry;
                        k_reg     <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    if (load)
                    begin
                        if (last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + LEN_W'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
                     wr_en |-> ((state_reg == S_IDLE) && !q_valid))
        else $error("Payload store written while a frame is still being drained.");

    assert property (@(posedge clk) disable iff (!rst_n)
                     (out_valid_reg && out_reg.byte_valid) |-> !out_reg.is_error)
        else $error("Error report carries a payload byte.");

    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == S_READ) |=> (state_reg == S_LOAD))
        else $error("Store read not followed by a result load.");

endmodule

/* rtl/framed_packet_parser_crc8.sv */
// Top level of the framed packet parser with CRC-8 check.
// Instantiates fpp_front, fpp_queue and fpp_back; depends on fpp_pkg.
//
// Received bytes enter on the s_axis channel, one byte per beat. The parser
// hunts for the start byte, reads the header and buffers up to PAYLOAD_DEPTH
// payload bytes while tracking a CRC-8 (polynomial 0x07, initial value 0).
// Results leave on the m_axis channel: one beat per payload byte of a good
// frame, one beat for an empty frame or for an error, with tlast on the final
// beat. The front end takes one byte per cycle unless the queue is full or the
// store is busy at a payload byte; a frame outcome goes into a two-entry
// command queue that feeds the back end. A frame outcome reaches m_axis via
// the queue, the back end's read and load states and the output register;
// payload beats follow one at a time: a registered store read, then the load.
// While a good frame drains, the front end keeps taking header bytes of the next
// frame but holds s_axis_tready low at its first payload byte until the drain
// ends. A stall on m_axis holds the output register and, once the queue is
// full, backs up into s_axis. Reset returns the parser to hunting, empties
// the queue and the output register, and loads the register reset values.
// Configuration writes take effect at the next edge and should be made idle.
module framed_packet_parser_crc8 #(
    parameter int PAYLOAD_DEPTH = fpp_pkg::PAYLOAD_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] rx_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] frame_version, [15:8] frame_command, [23:16] frame_interface,
    // [31:24] transaction_id, [38:32] payload_length, [39] byte_valid,
    // [47:40] payload_byte
    output logic [47:0]                     m_axis_tdata,
    output logic [2:0]                      m_axis_tuser,  // [0] is_error, [2:1] error_code
    output logic                            m_axis_tlast,  // last_of_frame
    input  logic                            cfg_we,
    input  logic [fpp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fpp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fpp_pkg::*;

    localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

    logic              q_push;
    fpp_cmd_t          q_push_entry;
    logic              q_full;
    logic              q_pop;
    fpp_cmd_t          q_pop_entry;
    logic              q_not_empty;
    logic              store_busy;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    fpp_result_t       result;

    fpp_front #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
        .ADDR_W        (ADDR_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_push     (q_push),
        .q_entry    (q_push_entry),
        .q_full     (q_full),
        .store_busy (store_busy),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    fpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (q_pop_entry),
        .not_empty  (q_not_empty)
    );

    fpp_back #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
        .ADDR_W        (ADDR_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_not_empty),
        .q_entry    (q_pop_entry),
        .q_pop      (q_pop),
        .store_busy (store_busy),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    always_comb
    begin
        m_axis_tdata = {result.payload_byte, result.byte_valid, result.payload_length,
                        result.transaction_id, result.frame_interface,
                        result.frame_command, result.frame_version};
        m_axis_tuser = {result.error_code, result.is_error};
        m_axis_tlast = result.last_of_frame;
    end

endmodule
